[rtl/tsrb_pkg.sv]
// ---------------------------------------------------------------------------
// tsrb_pkg
// Shared types and constants for the tilt-shift row blend core.
// ---------------------------------------------------------------------------
package tsrb_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;
	localparam int CFG_ROW_W  = 12;
	localparam int DECAY_W    = 7;

	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_ROW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BAND_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DECAY       = 2'd2;

	localparam int PIX_W    = 8;
	localparam int CH_N     = 3;
	localparam int ARG_FRAC = 10;
	localparam int ARG_QBITS = 15;
	localparam logic [ARG_QBITS-1:0] ARG_MAX = '1;
	localparam int ARG_SPAN  = 32768;
	localparam int DIV_STEPS = 4;
	localparam int DIV_STAGES = (ARG_QBITS + DIV_STEPS - 1) / DIV_STEPS;

	typedef enum logic [2:0] {
		FILL_PREP,
		FILL_DIV,
		FILL_WRITE,
		FILL_NEXT,
		FILL_DONE
	} fill_state_t;

endpackage

[rtl/tsrb_arg_unit.sv]
// ---------------------------------------------------------------------------
// tsrb_arg_unit
// Row distance to tanh table index: |d|*1024/decay rounded, saturated,
// then scaled to the table. Seven register stages, one item per cycle.
// ---------------------------------------------------------------------------
module tsrb_arg_unit import tsrb_pkg::*; #(
	parameter int ROW_BITS     = 12,
	parameter int TANH_ENTRIES = 1024
) (
	input  logic                            clk,
	input  logic signed [ROW_BITS+1:0]      delta,
	input  logic [DECAY_W-1:0]              dv,
	output logic [$clog2(TANH_ENTRIES)-1:0] idx,
	output logic                            neg
);

	localparam int IDX_W = $clog2(TANH_ENTRIES);
	localparam int MAG_W = ROW_BITS + 1;
	localparam int NUM_W = ROW_BITS + 12;
	localparam int HI_W  = NUM_W - ARG_QBITS;
	localparam int CW    = (HI_W > DECAY_W) ? HI_W : DECAY_W;

	logic [MAG_W-1:0]     mag_s1;
	logic                 neg_s1;
	logic [NUM_W-1:0]     num;
	logic [HI_W-1:0]      num_hi;
	logic [DECAY_W-1:0]   rem_s [0:DIV_STAGES];
	logic [ARG_QBITS-1:0] rq_s  [0:DIV_STAGES];
	logic                 sat_s [0:DIV_STAGES];
	logic                 neg_s [0:DIV_STAGES];
	logic [ARG_QBITS-1:0] x;
	logic [31:0]          scaled;
	logic [31:0]          idx_full;
	logic [IDX_W-1:0]     idx_s7;
	logic                 neg_s7;

	always_ff @(posedge clk) begin
		mag_s1 <= delta[ROW_BITS+1] ? MAG_W'(-delta) : MAG_W'(delta);
		neg_s1 <= delta[ROW_BITS+1];
	end

	// rounded numerator; quotient saturates once it reaches 2^15
	always_comb begin
		num    = NUM_W'({mag_s1, {ARG_FRAC{1'b0}}}) + NUM_W'(dv >> 1);
		num_hi = num[NUM_W-1:ARG_QBITS];
	end

	always_ff @(posedge clk) begin
		rem_s[0] <= DECAY_W'(num_hi);
		rq_s[0]  <= num[ARG_QBITS-1:0];
		sat_s[0] <= CW'(num_hi) >= CW'(dv);
		neg_s[0] <= neg_s1;
	end

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		localparam int NS = (ARG_QBITS - g * DIV_STEPS > DIV_STEPS) ?
			DIV_STEPS : ARG_QBITS - g * DIV_STEPS;
		logic [DECAY_W-1:0]   r;
		logic [ARG_QBITS-1:0] q;
		logic [DECAY_W:0]     t;

		always_comb begin
			r = rem_s[g];
			q = rq_s[g];
			t = '0;
			for (int i = 0; i < NS; i++) begin
				t = {r, q[ARG_QBITS-1]};
				q = {q[ARG_QBITS-2:0], 1'b0};
				if (t >= {1'b0, dv}) begin
					t    = t - {1'b0, dv};
					q[0] = 1'b1;
				end
				r = t[DECAY_W-1:0];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[g+1] <= r;
			rq_s[g+1]  <= q;
			sat_s[g+1] <= sat_s[g];
			neg_s[g+1] <= neg_s[g];
		end
	end

	always_comb begin
		x        = sat_s[DIV_STAGES] ? ARG_MAX : rq_s[DIV_STAGES];
		scaled   = 32'(x) * 32'(TANH_ENTRIES) + 32'(ARG_SPAN / 2);
		idx_full = scaled >> ARG_QBITS;
		if (idx_full > 32'(TANH_ENTRIES - 1))
			idx_full = 32'(TANH_ENTRIES - 1);
	end

	always_ff @(posedge clk) begin
		idx_s7 <= idx_full[IDX_W-1:0];
		neg_s7 <= neg_s[DIV_STAGES];
	end

	assign idx = idx_s7;
	assign neg = neg_s7;

endmodule

[rtl/tsrb_tanh_rom.sv]
// ---------------------------------------------------------------------------
// tsrb_tanh_rom
// Tanh table memory, two registered read ports. After reset the table is
// built entry by entry: p_k = e^-2x in Q1.32, entry = (1-p)/(1+p) by a
// bit-serial divider.
// ---------------------------------------------------------------------------
module tsrb_tanh_rom import tsrb_pkg::*; #(
	parameter int TANH_ENTRIES = 1024,
	parameter int ALPHA_BITS   = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [$clog2(TANH_ENTRIES)-1:0] rd_idx_a,
	input  logic [$clog2(TANH_ENTRIES)-1:0] rd_idx_b,
	output logic [ALPHA_BITS:0]             rd_data_a,
	output logic [ALPHA_BITS:0]             rd_data_b,
	output logic                            ready
);

	localparam int IDX_W  = $clog2(TANH_ENTRIES);
	localparam int K_W    = IDX_W + 1;
	localparam int STEP_W = $clog2(ALPHA_BITS + 1);
	localparam int DW     = 34 + ALPHA_BITS;
	localparam logic [63:0] ONE = 64'd1 << 32;
	localparam logic [63:0] TE  = 64'(TANH_ENTRIES);
	localparam logic [63:0] T1  = (ONE * 64) / (TE * 1);
	localparam logic [63:0] T2  = (T1 * 64) / (TE * 2);
	localparam logic [63:0] T3  = (T2 * 64) / (TE * 3);
	localparam logic [63:0] T4  = (T3 * 64) / (TE * 4);
	localparam logic [63:0] T5  = (T4 * 64) / (TE * 5);
	localparam logic [63:0] T6  = (T5 * 64) / (TE * 6);
	localparam logic [63:0] T7  = (T6 * 64) / (TE * 7);
	localparam logic [63:0] T8  = (T7 * 64) / (TE * 8);
	localparam logic [63:0] T9  = (T8 * 64) / (TE * 9);
	localparam logic [63:0] T10 = (T9 * 64) / (TE * 10);
	localparam logic [63:0] T11 = (T10 * 64) / (TE * 11);
	localparam logic [63:0] T12 = (T11 * 64) / (TE * 12);
	localparam logic [63:0] T13 = (T12 * 64) / (TE * 13);
	localparam logic [63:0] T14 = (T13 * 64) / (TE * 14);
	localparam logic [63:0] T15 = (T14 * 64) / (TE * 15);
	localparam logic [63:0] T16 = (T15 * 64) / (TE * 16);
	localparam logic [63:0] E64 = ONE - T1 + T2 - T3 + T4 - T5 + T6 - T7 + T8
		- T9 + T10 - T11 + T12 - T13 + T14 - T15 + T16;
	localparam logic [31:0] E32 = E64[31:0];

	logic [ALPHA_BITS:0] mem [TANH_ENTRIES];

	fill_state_t         state_q;
	fill_state_t         state_nxt;
	logic [32:0]         p_q;
	logic [K_W-1:0]      k_q;
	logic [63:0]         prod_q;
	logic [33:0]         den_q;
	logic [33:0]         rem_q;
	logic [ALPHA_BITS:0] dvd_q;
	logic [STEP_W-1:0]   step_q;
	logic [32:0]         num;
	logic [33:0]         den;
	logic [DW-1:0]       dend;
	logic [34:0]         trial;

	always_comb begin
		num   = 33'(ONE) - p_q;
		den   = 34'(ONE) + 34'(p_q);
		dend  = DW'({num, {ALPHA_BITS{1'b0}}}) + DW'(den >> 1);
		trial = {rem_q, dvd_q[ALPHA_BITS]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FILL_PREP;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			FILL_PREP:  state_nxt = FILL_DIV;
			FILL_DIV: begin
				if (step_q == STEP_W'(ALPHA_BITS))
					state_nxt = FILL_WRITE;
			end
			FILL_WRITE: state_nxt = FILL_NEXT;
			FILL_NEXT: begin
				if (k_q == K_W'(TANH_ENTRIES))
					state_nxt = FILL_DONE;
				else
					state_nxt = FILL_PREP;
			end
			FILL_DONE:  state_nxt = FILL_DONE;
			default:    state_nxt = FILL_PREP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q <= 33'(ONE);
			k_q <= '0;
		end else begin
			case (state_q)
				FILL_WRITE: k_q <= k_q + 1'b1;
				FILL_NEXT:  p_q <= {1'b0, prod_q[63:32]};
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			FILL_PREP: begin
				den_q  <= den;
				rem_q  <= 34'(dend >> (ALPHA_BITS + 1));
				dvd_q  <= dend[ALPHA_BITS:0];
				step_q <= '0;
			end
			FILL_DIV: begin
				if (trial >= {1'b0, den_q}) begin
					rem_q <= 34'(trial - {1'b0, den_q});
					dvd_q <= {dvd_q[ALPHA_BITS-1:0], 1'b1};
				end else begin
					rem_q <= trial[33:0];
					dvd_q <= {dvd_q[ALPHA_BITS-1:0], 1'b0};
				end
				step_q <= step_q + 1'b1;
			end
			FILL_WRITE: begin
				// p is exactly one only for the first entry
				prod_q <= p_q[32] ? {E32, 32'd0} : 64'(p_q[31:0]) * 64'(E32);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == FILL_WRITE)
			mem[k_q[IDX_W-1:0]] <= dvd_q;
	end

	always_ff @(posedge clk) begin
		rd_data_a <= mem[rd_idx_a];
		rd_data_b <= mem[rd_idx_b];
	end

	assign ready = (state_q == FILL_DONE);

endmodule

[rtl/tilt_shift_row_blend_core.sv]
// ---------------------------------------------------------------------------
// tilt_shift_row_blend_core
// Each request passes the row input, arg unit, tanh read, alpha, product and
// output registers before done; one request per cycle while busy is low.
// After reset busy stays high while the tanh table is built, one entry per
// serial divide. Registers reset to centre 0, height 0, decay 1; results
// cannot be stalled.
// ---------------------------------------------------------------------------
module tilt_shift_row_blend_core import tsrb_pkg::*; #(
	parameter int ROW_BITS     = 12,
	parameter int TANH_ENTRIES = 1024,
	parameter int ALPHA_BITS   = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  start,
	output logic                  busy,
	input  logic [ROW_BITS-1:0]   row,
	input  logic [PIX_W-1:0]      sharp_red,
	input  logic [PIX_W-1:0]      sharp_green,
	input  logic [PIX_W-1:0]      sharp_blue,
	input  logic [PIX_W-1:0]      blur_red,
	input  logic [PIX_W-1:0]      blur_green,
	input  logic [PIX_W-1:0]      blur_blue,
	output logic                  done,
	output logic [PIX_W-1:0]      out_red,
	output logic [PIX_W-1:0]      out_green,
	output logic [PIX_W-1:0]      out_blue,
	output logic [15:0]           weight
);

	localparam int IDX_W = $clog2(TANH_ENTRIES);
	localparam int LAST  = 12;
	localparam int PIX_LAST = 10;
	localparam int TW    = ALPHA_BITS + 3;
	localparam logic [ALPHA_BITS-1:0] AMAX = '1;
	localparam logic [ALPHA_BITS:0]   AONE = (ALPHA_BITS + 1)'(1) << ALPHA_BITS;
	localparam logic [ALPHA_BITS+9:0] AHALF = (ALPHA_BITS + 10)'(1) << (ALPHA_BITS - 1);

	logic [CFG_ROW_W-1:0] center_q;
	logic [CFG_ROW_W-1:0] band_q;
	logic [DECAY_W-1:0]   decay_q;
	logic [DECAY_W-1:0]   dv;
	logic                 ready;
	logic                 accept;

	logic                 v_s [1:LAST];
	logic [ROW_BITS-1:0]  row_s1;
	logic [PIX_W-1:0]     sharp_s [1:PIX_LAST][CH_N];
	logic [PIX_W-1:0]     blur_s  [1:PIX_LAST][CH_N];

	logic [ROW_BITS-1:0]     center_r;
	logic [ROW_BITS-1:0]     half_r;
	logic signed [ROW_BITS+1:0] row_x;
	logic signed [ROW_BITS+1:0] dist_top;
	logic signed [ROW_BITS+1:0] dist_bot;

	logic [IDX_W-1:0]    idx_top;
	logic [IDX_W-1:0]    idx_bot;
	logic                neg_top;
	logic                neg_bot;
	logic                neg_top_s9;
	logic                neg_bot_s9;
	logic [ALPHA_BITS:0] tanh_top_s9;
	logic [ALPHA_BITS:0] tanh_bot_s9;

	logic signed [TW-1:0] t_top;
	logic signed [TW-1:0] t_bot;
	logic signed [TW-1:0] diff;
	logic signed [TW-1:0] half_up;
	logic [ALPHA_BITS:0]  a_raw;
	logic [ALPHA_BITS-1:0] alpha;

	logic [ALPHA_BITS-1:0]  alpha_s10;
	logic [ALPHA_BITS-1:0]  alpha_s11;
	logic [ALPHA_BITS-1:0]  alpha_s12;
	logic [ALPHA_BITS+7:0]  ps_s11 [CH_N];
	logic [ALPHA_BITS+8:0]  pb_s11 [CH_N];
	logic [ALPHA_BITS+9:0]  mix_sum [CH_N];
	logic [9:0]             mix_hi [CH_N];
	logic [PIX_W-1:0]       out_s12 [CH_N];

	assign cfg_ready = 1'b1;
	assign busy      = !ready;
	assign accept    = start && ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q <= '0;
			band_q   <= '0;
			decay_q  <= DECAY_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_CENTER_ROW:  center_q <= cfg_data[CFG_ROW_W-1:0];
				CFG_BAND_HEIGHT: band_q   <= cfg_data[CFG_ROW_W-1:0];
				CFG_DECAY:       decay_q  <= cfg_data[DECAY_W-1:0];
				default: ;
			endcase
		end
	end

	// zero decay acts as one
	assign dv = (decay_q == '0) ? DECAY_W'(1) : decay_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= LAST; i++)
				v_s[i] <= 1'b0;
		end else begin
			v_s[1] <= accept;
			for (int i = 2; i <= LAST; i++)
				v_s[i] <= v_s[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			row_s1        <= row;
			sharp_s[1][0] <= sharp_red;
			sharp_s[1][1] <= sharp_green;
			sharp_s[1][2] <= sharp_blue;
			blur_s[1][0]  <= blur_red;
			blur_s[1][1]  <= blur_green;
			blur_s[1][2]  <= blur_blue;
		end
		for (int i = 2; i <= PIX_LAST; i++) begin
			sharp_s[i] <= sharp_s[i-1];
			blur_s[i]  <= blur_s[i-1];
		end
	end

	always_comb begin
		center_r = ROW_BITS'(center_q);
		half_r   = ROW_BITS'(band_q) >> 1;
		row_x    = $signed({2'b00, row_s1});
		dist_top = row_x - $signed({2'b00, center_r}) + $signed({2'b00, half_r});
		dist_bot = row_x - $signed({2'b00, center_r}) - $signed({2'b00, half_r});
	end

	tsrb_arg_unit #(
		.ROW_BITS     (ROW_BITS),
		.TANH_ENTRIES (TANH_ENTRIES)
	) u_arg_top (
		.clk   (clk),
		.delta (dist_top),
		.dv    (dv),
		.idx   (idx_top),
		.neg   (neg_top)
	);

	tsrb_arg_unit #(
		.ROW_BITS     (ROW_BITS),
		.TANH_ENTRIES (TANH_ENTRIES)
	) u_arg_bot (
		.clk   (clk),
		.delta (dist_bot),
		.dv    (dv),
		.idx   (idx_bot),
		.neg   (neg_bot)
	);

	tsrb_tanh_rom #(
		.TANH_ENTRIES (TANH_ENTRIES),
		.ALPHA_BITS   (ALPHA_BITS)
	) u_tanh (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_idx_a  (idx_top),
		.rd_idx_b  (idx_bot),
		.rd_data_a (tanh_top_s9),
		.rd_data_b (tanh_bot_s9),
		.ready     (ready)
	);

	always_ff @(posedge clk) begin
		neg_top_s9 <= neg_top;
		neg_bot_s9 <= neg_bot;
	end

	always_comb begin
		t_top   = neg_top_s9 ? -$signed({2'b00, tanh_top_s9}) : $signed({2'b00, tanh_top_s9});
		t_bot   = neg_bot_s9 ? -$signed({2'b00, tanh_bot_s9}) : $signed({2'b00, tanh_bot_s9});
		diff    = t_top - t_bot;
		half_up = (diff + TW'(1)) >>> 1;
		a_raw   = diff[TW-1] ? '0 : half_up[ALPHA_BITS:0];
		alpha   = (a_raw > {1'b0, AMAX}) ? AMAX : a_raw[ALPHA_BITS-1:0];
	end

	always_ff @(posedge clk) begin
		alpha_s10 <= alpha;
		alpha_s11 <= alpha_s10;
		alpha_s12 <= alpha_s11;
		for (int c = 0; c < CH_N; c++) begin
			ps_s11[c] <= (ALPHA_BITS + 8)'(sharp_s[PIX_LAST][c]) *
				(ALPHA_BITS + 8)'(alpha_s10);
			pb_s11[c] <= (ALPHA_BITS + 9)'(blur_s[PIX_LAST][c]) *
				(ALPHA_BITS + 9)'(AONE - {1'b0, alpha_s10});
		end
	end

	always_comb begin
		for (int c = 0; c < CH_N; c++) begin
			mix_sum[c] = (ALPHA_BITS + 10)'(ps_s11[c]) + (ALPHA_BITS + 10)'(pb_s11[c]) + AHALF;
			mix_hi[c]  = mix_sum[c][ALPHA_BITS+9:ALPHA_BITS];
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < CH_N; c++)
			out_s12[c] <= (mix_hi[c] > 10'd255) ? 8'd255 : mix_hi[c][PIX_W-1:0];
	end

	assign done      = v_s[LAST];
	assign out_red   = out_s12[0];
	assign out_green = out_s12[1];
	assign out_blue  = out_s12[2];
	assign weight    = 16'(alpha_s12);

endmodule

[sim/tsrb_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tsrb_checker
// Watches the config and pixel channels of the tilt-shift row blend core.
// Predicts each blended pixel and its row weight, and compares it with the
// next result, in order.
// ---------------------------------------------------------------------------
module tsrb_checker import tsrb_pkg::*; #(
	parameter int ROW_BITS     = 12,
	parameter int TANH_ENTRIES = 1024,
	parameter int ALPHA_BITS   = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  start,
	input  logic                  busy,
	input  logic [ROW_BITS-1:0]   row,
	input  logic [PIX_W-1:0]      sharp_red,
	input  logic [PIX_W-1:0]      sharp_green,
	input  logic [PIX_W-1:0]      sharp_blue,
	input  logic [PIX_W-1:0]      blur_red,
	input  logic [PIX_W-1:0]      blur_green,
	input  logic [PIX_W-1:0]      blur_blue,
	input  logic                  done,
	input  logic [PIX_W-1:0]      out_red,
	input  logic [PIX_W-1:0]      out_green,
	input  logic [PIX_W-1:0]      out_blue,
	input  logic [15:0]           weight,
	output int                    fail_count,
	output int                    pending
);

	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
		logic [15:0]      weight;
	} blend_t;

	longint unsigned tanh_lut [TANH_ENTRIES];
	logic [CFG_ROW_W-1:0] centre_q;
	logic [CFG_ROW_W-1:0] height_q;
	logic [DECAY_W-1:0]   decay_q;
	blend_t               blend_q [$];
	int                   errs = 0;

	// tanh in Q0.ALPHA_BITS, integer-only build from a truncated exp series
	initial begin
		longint unsigned one, term, e, p, num, den;
		one  = 64'd1 << 32;
		term = one;
		e    = one;
		p    = one;
		for (int n = 1; n <= 16; n++) begin
			term = (term * 64'd64) / (64'(TANH_ENTRIES) * 64'(n));
			if (n % 2)
				e -= term;
			else
				e += term;
		end
		for (int k = 0; k < TANH_ENTRIES; k++) begin
			num = one - p;
			den = one + p;
			tanh_lut[k] = ((num << ALPHA_BITS) + den / 2) / den;
			p = (p * e) >> 32;
		end
	end

	function automatic longint tanh_q(longint d, longint unsigned dv);
		longint unsigned mag, x, idx;
		mag = (d < 0) ? unsigned'(-d) : unsigned'(d);
		x = (mag * 1024 + dv / 2) / dv;
		if (x > ARG_MAX)
			x = ARG_MAX;
		idx = (x * TANH_ENTRIES + ARG_SPAN / 2) / ARG_SPAN;
		if (idx > TANH_ENTRIES - 1)
			idx = TANH_ENTRIES - 1;
		return (d < 0) ? -longint'(tanh_lut[idx]) : longint'(tanh_lut[idx]);
	endfunction

	function automatic logic [PIX_W-1:0] mix_chan(longint unsigned s, longint unsigned b,
			longint unsigned a);
		longint unsigned one, v;
		one = 64'd1 << ALPHA_BITS;
		v = (s * a + b * (one - a) + (one >> 1)) >> ALPHA_BITS;
		return (v > 255) ? 8'd255 : v[PIX_W-1:0];
	endfunction

	function automatic blend_t blend_expect();
		longint unsigned rmask, dv, a, amax;
		longint          r, c, half, diff;
		blend_t          res;
		rmask = (64'd1 << ROW_BITS) - 1;
		amax  = (64'd1 << ALPHA_BITS) - 1;
		r     = row & rmask;
		c     = centre_q & rmask;
		half  = (height_q & rmask) >> 1;
		dv    = (decay_q == 0) ? 1 : decay_q;
		diff  = tanh_q(r - (c - half), dv) - tanh_q(r - (c + half), dv);
		if (diff < 0)
			diff = 0;
		a = (unsigned'(diff) + 1) >> 1;
		if (a > amax)
			a = amax;
		res.red    = mix_chan(sharp_red, blur_red, a);
		res.green  = mix_chan(sharp_green, blur_green, a);
		res.blue   = mix_chan(sharp_blue, blur_blue, a);
		res.weight = a[15:0];
		return res;
	endfunction

	function automatic int field_bad(string name, logic [31:0] want_v, logic [31:0] got_v);
		if (want_v === got_v)
			return 0;
		$error("%s: expected %0d, actual %0d", name, want_v, got_v);
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			centre_q <= '0;
			height_q <= '0;
			decay_q  <= 7'd1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_CENTER_ROW:  centre_q <= cfg_data[CFG_ROW_W-1:0];
				CFG_BAND_HEIGHT: height_q <= cfg_data[CFG_ROW_W-1:0];
				CFG_DECAY:       decay_q  <= cfg_data[DECAY_W-1:0];
				default: ;
			endcase
		end
	end

	always @(posedge clk) begin
		blend_t want;
		if (arst_n) begin
			if (done === 1'b1) begin
				if (blend_q.size() == 0) begin
					$error("result with no request outstanding");
					errs++;
				end else begin
					want = blend_q.pop_front();
					errs += field_bad("out_red", want.red, out_red)
						+ field_bad("out_green", want.green, out_green)
						+ field_bad("out_blue", want.blue, out_blue)
						+ field_bad("weight", want.weight, weight);
				end
			end
			if (start && busy === 1'b0)
				blend_q.push_back(blend_expect());
		end
		pending    <= blend_q.size();
		fail_count <= errs;
	end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Stimulus for the tilt-shift row blend core: directed band, decay and pixel
// extremes, then random phases of rows clustered on the band edges.
// ---------------------------------------------------------------------------
module tb_top;
	import tsrb_pkg::*;

	localparam int ROW_BITS     = 12;
	localparam int TANH_ENTRIES = 1024;
	localparam int ALPHA_BITS   = 16;
	localparam int LATENCY      = 12;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int ROW_MAX      = (1 << ROW_BITS) - 1;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  start = 1'b0;
	logic [ROW_BITS-1:0]   row = '0;
	logic [PIX_W-1:0]      sharp_red = '0, sharp_green = '0, sharp_blue = '0;
	logic [PIX_W-1:0]      blur_red = '0, blur_green = '0, blur_blue = '0;
	logic                  cfg_ready, busy, done;
	logic [PIX_W-1:0]      out_red, out_green, out_blue;
	logic [15:0]           weight;
	int                    fail_count, pending;
	int                    centre_set = 0, height_set = 0, decay_set = 1;

	tilt_shift_row_blend_core #(
		.ROW_BITS(ROW_BITS), .TANH_ENTRIES(TANH_ENTRIES), .ALPHA_BITS(ALPHA_BITS)
	) dut (.*);

	tsrb_checker #(
		.ROW_BITS(ROW_BITS), .TANH_ENTRIES(TANH_ENTRIES), .ALPHA_BITS(ALPHA_BITS)
	) checker_i (.*);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("** tilt_shift_row_blend_core: FAILED **");
		$finish;
	end

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		int gap;
		gap = $urandom_range(0, 3);
		if (gap > 0) begin
			cfg_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_CENTER_ROW:  centre_set = int'(val);
			CFG_BAND_HEIGHT: height_set = int'(val);
			CFG_DECAY:       decay_set  = int'(val[DECAY_W-1:0]);
			default: ;
		endcase
	endtask

	// all three registers, starting at a random one; junk above the decay field
	task automatic setup(int c, int h, int d, bit spare);
		logic [CFG_DATA_W-1:0] dword;
		int first;
		dword = CFG_DATA_W'($urandom);
		dword[DECAY_W-1:0] = DECAY_W'(d);
		first = $urandom_range(0, 2);
		for (int i = 0; i < 3; i++) begin
			case ((first + i) % 3)
				0: cfg_write(CFG_CENTER_ROW, CFG_DATA_W'(c));
				1: cfg_write(CFG_BAND_HEIGHT, CFG_DATA_W'(h));
				default: cfg_write(CFG_DECAY, dword);
			endcase
		end
		if (spare)
			cfg_write(CFG_SPARE, CFG_DATA_W'($urandom));
		cfg_valid <= 1'b0;
	endtask

	task automatic send_pixel(int r, logic [CH_N*PIX_W-1:0] sharp,
			logic [CH_N*PIX_W-1:0] blur, int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		row   <= ROW_BITS'(r);
		{sharp_red, sharp_green, sharp_blue} <= sharp;
		{blur_red, blur_green, blur_blue}    <= blur;
		do @(posedge clk); while (busy);
	endtask

	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	function automatic logic [PIX_W-1:0] pix_value();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(0, 1) ? 8'd255 : 8'd0;
		return PIX_W'($urandom_range(0, 255));
	endfunction

	// half the rows land within a few decays of a band edge
	task automatic random_pixel(bit burst);
		int r, dv, off, pick;
		dv   = (decay_set == 0) ? 1 : decay_set;
		pick = $urandom_range(0, 3);
		if (pick < 2) begin
			off = $urandom_range(0, 8 * dv);
			r = (pick == 0) ? centre_set - height_set / 2 : centre_set + height_set / 2;
			r = $urandom_range(0, 1) ? r + off : r - off;
		end else begin
			r = $urandom_range(0, ROW_MAX);
		end
		if (r < 0)
			r = 0;
		if (r > ROW_MAX)
			r = ROW_MAX;
		send_pixel(r, {pix_value(), pix_value(), pix_value()},
			{pix_value(), pix_value(), pix_value()}, burst ? 0 : $urandom_range(0, 3));
	endtask

	initial begin
		int c, h, d;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: zero-height band
		send_pixel(0, 24'hFFFFFF, 24'h000000, 0);
		send_pixel(ROW_MAX, 24'h000000, 24'hFFFFFF, 1);
		send_pixel(2048, 24'hFF00FF, 24'h00FF00, 0);
		send_pixel(100, 24'h00FF00, 24'hFF00FF, 2);
		drain();

		setup(2048, 200, 10, 1'b1);
		send_pixel(1948, 24'hFFFFFF, 24'h000000, 0);
		send_pixel(2148, 24'hFFFFFF, 24'h000000, 0);
		send_pixel(2048, 24'h123456, 24'hFEDCBA, 3);
		send_pixel(0, 24'hFFFFFF, 24'h000000, 0);
		send_pixel(ROW_MAX, 24'h000000, 24'hFFFFFF, 1);
		send_pixel(1949, 24'h80FF7F, 24'h7F0080, 0);
		drain();

		// zero decay, band top far above the frame
		setup(0, 4095, 0, 1'b0);
		send_pixel(0, 24'hFFFFFF, 24'h000000, 0);
		send_pixel(2047, 24'hFFFFFF, 24'h000000, 0);
		send_pixel(2048, 24'hFFFFFF, 24'h000000, 2);
		send_pixel(ROW_MAX, 24'hAA55AA, 24'h55AA55, 0);
		drain();

		// maximum decay, band bottom past the last row
		setup(4095, 4095, 127, 1'b0);
		send_pixel(0, 24'hFFFFFF, 24'h000000, 0);
		send_pixel(2048, 24'hFFFFFF, 24'h000000, 1);
		send_pixel(ROW_MAX, 24'hFFFFFF, 24'h000000, 0);
		drain();

		setup(10, 1, 101, 1'b0);
		send_pixel(10, 24'hFFFFFF, 24'h000000, 0);
		send_pixel(9, 24'hFFFFFF, 24'h000000, 0);
		send_pixel(11, 24'h000000, 24'hFFFFFF, 0);
		send_pixel(ROW_MAX, 24'hFFFFFF, 24'h000000, 3);
		drain();

		// saturated tanh arguments
		setup(3000, 0, 1, 1'b0);
		send_pixel(3000, 24'hFFFFFF, 24'h000000, 0);
		send_pixel(0, 24'hFFFFFF, 24'h000000, 0);
		drain();

		for (int ph = 0; ph < 10; ph++) begin
			case (ph % 5)
				0: begin
					c = $urandom_range(0, 4095);
					h = $urandom_range(0, 600);
					d = $urandom_range(1, 101);
				end
				1: begin
					c = $urandom_range(0, 4095);
					h = $urandom_range(0, 4095);
					d = $urandom_range(0, 127);
				end
				2: begin
					c = $urandom_range(0, 1) ? 4095 : 0;
					h = $urandom_range(0, 1) ? 4095 : 0;
					case ($urandom_range(0, 3))
						0: d = 0;
						1: d = 1;
						2: d = 101;
						default: d = 127;
					endcase
				end
				3: begin
					c = $urandom_range(0, 4095);
					h = $urandom_range(0, 200);
					d = $urandom_range(0, 3);
				end
				default: begin
					c = $urandom_range(0, 4095);
					h = $urandom_range(0, 1000);
					d = $urandom_range(90, 127);
				end
			endcase
			setup(c, h, d, $urandom_range(0, 3) == 0);
			for (int i = 0; i < 200; i++)
				random_pixel(ph % 3 == 0);
			drain();
		end

		repeat (2 * LATENCY) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("** tilt_shift_row_blend_core: PASSED **");
		else
			$display("** tilt_shift_row_blend_core: FAILED **");
		$finish;
	end

endmodule

[tilt_shift_row_blend_core.f]
rtl/tsrb_pkg.sv
rtl/tsrb_arg_unit.sv
rtl/tsrb_tanh_rom.sv
rtl/tilt_shift_row_blend_core.sv
sim/tsrb_checker.sv
sim/tb_top.sv
